// ----- src/ifse_pkg.sv -----
// Shared types, register map and reset values for the info frame stuffing encoder.
package ifse_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned QUEUE_DEPTH   = 4;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLAG       = 3'd0,
		REG_ESCAPE     = 3'd1,
		REG_FLAG_SUB   = 3'd2,
		REG_ESCAPE_SUB = 3'd3,
		REG_ADDRESS    = 3'd4,
		REG_CTRL_SEQ0  = 3'd5,
		REG_CTRL_SEQ1  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_value;
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] flag_substitute;
		logic [BYTE_W-1:0] escape_substitute;
		logic [BYTE_W-1:0] sender_address;
		logic [BYTE_W-1:0] control_seq0;
		logic [BYTE_W-1:0] control_seq1;
	} cfg_t;

	localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd126;

	localparam cfg_t CFG_RESET = '{
		flag_value:        FLAG_RESET,
		escape_value:      8'd125,
		flag_substitute:   8'd94,
		escape_substitute: 8'd93,
		sender_address:    8'd3,
		control_seq0:      8'd0,
		control_seq1:      8'd64
	};

	// One classified payload byte as handed from the front end to the back end.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] check;   // data check including this byte
		logic              hdr;     // first byte of a frame: header goes first
		logic              seq;
		logic              last;
	} job_t;

	localparam int unsigned JOB_W = $bits(job_t);

endpackage

// ----- src/ifse_queue.sv -----
// Small first-in first-out queue between the front end and the back end.
module ifse_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/ifse_front.sv -----
// Front end: accepts payload bytes, tracks frame position and the running data check.
module ifse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	input  logic          s_tuser,
	input  logic          queue_full,
	output logic          push,
	output ifse_pkg::job_t job
);
	import ifse_pkg::*;

	logic              in_frame_q;
	logic [BYTE_W-1:0] check_q;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		job.data  = s_tdata;
		job.hdr   = !in_frame_q;
		job.seq   = s_tuser;
		job.last  = s_tlast;
		// A new frame restarts the check from zero.
		job.check = (in_frame_q ? check_q : '0) ^ s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			check_q    <= '0;
		end else if (push) begin
			in_frame_q <= !s_tlast;
			check_q    <= s_tlast ? '0 : job.check;
		end
	end

endmodule

// ----- src/ifse_back.sv -----
// Back end: walks each queued byte through header, stuffing, check and closing flag.
module ifse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ifse_pkg::cfg_t cfg,
	input  logic           head_valid,
	input  ifse_pkg::job_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);
	import ifse_pkg::*;

	typedef enum logic [9:0] {
		ST_START = 10'b00_0000_0001,
		ST_FLAG  = 10'b00_0000_0010,
		ST_ADDR  = 10'b00_0000_0100,
		ST_CTRL  = 10'b00_0000_1000,
		ST_HCHK  = 10'b00_0001_0000,
		ST_DATA  = 10'b00_0010_0000,
		ST_DSUB  = 10'b00_0100_0000,
		ST_CHK   = 10'b00_1000_0000,
		ST_CSUB  = 10'b01_0000_0000,
		ST_CLOSE = 10'b10_0000_0000
	} step_t;

	step_t             state_q;
	step_t             step;
	step_t             nxt;
	logic [BYTE_W-1:0] ctrl;
	logic [BYTE_W-1:0] byte_d;
	logic              end_d;
	logic              fire;
	logic              data_is_flag;
	logic              data_is_esc;
	logic              chk_is_flag;
	logic              chk_is_esc;

	assign ctrl         = head.seq ? cfg.control_seq1 : cfg.control_seq0;
	assign data_is_flag = (head.data == cfg.flag_value);
	assign data_is_esc  = (head.data == cfg.escape_value);
	assign chk_is_flag  = (head.check == cfg.flag_value);
	assign chk_is_esc   = (head.check == cfg.escape_value);

	assign fire = head_valid && (!m_tvalid || m_tready);
	assign step = (state_q == ST_START) ? (head.hdr ? ST_FLAG : ST_DATA) : state_q;

	always_comb begin
		byte_d = '0;
		end_d  = 1'b0;
		nxt    = ST_START;
		unique case (step)
			ST_FLAG: begin
				byte_d = cfg.flag_value;
				nxt    = ST_ADDR;
			end
			ST_ADDR: begin
				byte_d = cfg.sender_address;
				nxt    = ST_CTRL;
			end
			ST_CTRL: begin
				byte_d = ctrl;
				nxt    = ST_HCHK;
			end
			ST_HCHK: begin
				byte_d = cfg.sender_address ^ ctrl;
				nxt    = ST_DATA;
			end
			ST_DATA: begin
				if (data_is_flag || data_is_esc) begin
					byte_d = cfg.escape_value;
					nxt    = ST_DSUB;
				end else begin
					byte_d = head.data;
					nxt    = head.last ? ST_CHK : ST_START;
				end
			end
			ST_DSUB: begin
				// The flag compare wins when flag and escape are equal.
				byte_d = data_is_flag ? cfg.flag_substitute : cfg.escape_substitute;
				nxt    = head.last ? ST_CHK : ST_START;
			end
			ST_CHK: begin
				if (chk_is_flag || chk_is_esc) begin
					byte_d = cfg.escape_value;
					nxt    = ST_CSUB;
				end else begin
					byte_d = head.check;
					nxt    = ST_CLOSE;
				end
			end
			ST_CSUB: begin
				byte_d = chk_is_flag ? cfg.flag_substitute : cfg.escape_substitute;
				nxt    = ST_CLOSE;
			end
			ST_CLOSE: begin
				byte_d = cfg.flag_value;
				end_d  = 1'b1;
				nxt    = ST_START;
			end
			default: begin
				nxt = ST_START;
			end
		endcase
	end

	assign pop = fire && (nxt == ST_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			m_tvalid <= 1'b0;
		end else if (fire) begin
			state_q  <= nxt;
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= byte_d;
			m_tlast <= end_d;
		end
	end

endmodule

// ----- src/info_frame_stuffing_encoder.sv -----
// Top level of the byte-stuffing information frame encoder.
//
//  Channel  Direction  Payload
//  -------  ---------  ----------------------------------------------------
//  s_*      in         tdata = data_byte, tlast = last_byte, tuser = seq_bit
//  m_*      out        tdata = out_byte, tlast = frame_end
//  cfg_*    in         cfg_index = register index, cfg_data = register value
//
// Each accepted payload byte produces one to nine output bytes, one per clock on
// the output port while it is not stalled: four header bytes on the first byte of
// a frame, one or two for the stuffed byte, and on the last byte one or two for
// the stuffed check plus the closing flag. The output port, at one byte per
// cycle, sets the throughput. The input side accepts a byte in every cycle while
// the queue between front and back end has room, so a stalled output only holds
// off the input once the queue is full. Reset is asynchronous and needs no
// clearing pass; the block takes transfers as soon as reset is released.
module info_frame_stuffing_encoder #(
	parameter int unsigned QUEUE_DEPTH = ifse_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	input  logic       s_tuser,   // [0] seq_bit
	// Output stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // frame_end
	// Configuration writes.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import ifse_pkg::*;

	cfg_t             cfg_q;
	job_t             push_job;
	job_t             head_job;
	logic [JOB_W-1:0] head_bits;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             head_valid;

	// Registers are always ready; an index past the map is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FLAG:       cfg_q.flag_value        <= cfg_data;
				REG_ESCAPE:     cfg_q.escape_value      <= cfg_data;
				REG_FLAG_SUB:   cfg_q.flag_substitute   <= cfg_data;
				REG_ESCAPE_SUB: cfg_q.escape_substitute <= cfg_data;
				REG_ADDRESS:    cfg_q.sender_address    <= cfg_data;
				REG_CTRL_SEQ0:  cfg_q.control_seq0      <= cfg_data;
				REG_CTRL_SEQ1:  cfg_q.control_seq1      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end classifies each byte as header-opening and/or closing and
	// carries the running check along with it.
	ifse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	ifse_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_bits)
	);

	assign head_job = job_t'(head_bits);

	// The back end emits the bytes for the queue head one per cycle while the output is not stalled.
	ifse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- src/ifse_checker.sv -----
// Port-level checks for the info frame stuffing encoder, bound to the top level.
module ifse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data
);
	import ifse_pkg::*;

	logic [BYTE_W-1:0] flag_q;

	// Mirror of the flag register, followed from the configuration transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= FLAG_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_FLAG)) begin
			flag_q <= cfg_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_close_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == flag_q)
		else $error("frame end byte is not the flag");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

	// The byte is written into the queue first, and its first output byte is then registered at the output port.
	a_accept_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
		else $error("accepted byte produced no output on an idle port");

endmodule

bind info_frame_stuffing_encoder ifse_checker u_ifse_checker (.*);

// ----- dv/info_frame_stuffing_encoder_tb.sv -----
// Self-checking testbench for the info frame stuffing encoder: frame scoreboard and stimulus.
`timescale 1ns / 100ps

// One byte of the framed output stream as the scoreboard expects it.
typedef struct packed {
	logic [7:0] value;
	logic       closing;
} framed_byte_t;

// Predicts the framed, stuffed byte stream from accepted payload transfers and
// matches it against the output stream in order.
class frame_scoreboard;
	ifse_pkg::cfg_t regs;
	bit             in_frame;
	logic [7:0]     running_check;
	framed_byte_t   pending_bytes[$];
	int unsigned    mismatches;

	function new();
		regs          = ifse_pkg::CFG_RESET;
		in_frame      = 1'b0;
		running_check = 8'h00;
		mismatches    = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [7:0] value);
		case (idx)
			ifse_pkg::REG_FLAG:       regs.flag_value        = value;
			ifse_pkg::REG_ESCAPE:     regs.escape_value      = value;
			ifse_pkg::REG_FLAG_SUB:   regs.flag_substitute   = value;
			ifse_pkg::REG_ESCAPE_SUB: regs.escape_substitute = value;
			ifse_pkg::REG_ADDRESS:    regs.sender_address    = value;
			ifse_pkg::REG_CTRL_SEQ0:  regs.control_seq0      = value;
			ifse_pkg::REG_CTRL_SEQ1:  regs.control_seq1      = value;
			default: ;
		endcase
	endfunction

	function void push(logic [7:0] value, logic closing);
		framed_byte_t b;
		b.value   = value;
		b.closing = closing;
		pending_bytes.push_back(b);
	endfunction

	// The flag comparison wins when flag and escape hold the same value.
	function void push_stuffed(logic [7:0] value);
		if (value == regs.flag_value) begin
			push(regs.escape_value, 1'b0);
			push(regs.flag_substitute, 1'b0);
		end else if (value == regs.escape_value) begin
			push(regs.escape_value, 1'b0);
			push(regs.escape_substitute, 1'b0);
		end else begin
			push(value, 1'b0);
		end
	endfunction

	function void take_payload(logic [7:0] data, logic last, logic seq);
		logic [7:0] ctrl;
		if (!in_frame) begin
			ctrl = seq ? regs.control_seq1 : regs.control_seq0;
			push(regs.flag_value, 1'b0);
			push(regs.sender_address, 1'b0);
			push(ctrl, 1'b0);
			push(regs.sender_address ^ ctrl, 1'b0);
			running_check = 8'h00;
			in_frame      = 1'b1;
		end
		push_stuffed(data);
		running_check = running_check ^ data;
		if (last) begin
			push_stuffed(running_check);
			push(regs.flag_value, 1'b1);
			in_frame      = 1'b0;
			running_check = 8'h00;
		end
	endfunction

	function void report(string what, logic [7:0] exp_value, logic exp_closing,
			logic [7:0] got_value, logic got_closing);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s: expected %02h end %0b, got %02h end %0b", $time, what,
				exp_value, exp_closing, got_value, got_closing);
	endfunction

	function void match_output(logic [7:0] value, logic closing);
		framed_byte_t want;
		if (pending_bytes.size() == 0) begin
			report("output byte with nothing pending", 8'hxx, 1'bx, value, closing);
		end else begin
			want = pending_bytes.pop_front();
			if (want.value !== value || want.closing !== closing)
				report("output byte mismatch", want.value, want.closing, value, closing);
		end
	endfunction
endclass

module info_frame_stuffing_encoder_tb;
	import ifse_pkg::*;

	// Index past the register map; a write there must leave every register alone.
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	// Cycles allowed after the last expected byte for anything stray to show up.
	localparam int unsigned SETTLE_CYCLES = 16;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int unsigned send_gap_pct;
	int unsigned stall_pct;

	frame_scoreboard sb;

	info_frame_stuffing_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#5ms;
		$display("info_frame_stuffing_encoder verification failed");
		$finish;
	end

	// Receiver: stalls at random, and every output transfer is checked at the
	// rising edge against the oldest pending byte.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.match_output(m_tdata, m_tlast);
		end
	end

	// Presents one payload byte, possibly after some idle cycles, and waits for
	// its transfer. Entered and left at a falling edge with s_tvalid still high,
	// so back-to-back bytes keep the valid up.
	task automatic send_payload(input logic [7:0] data, input logic last, input logic seq);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		s_tuser  <= seq;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.take_payload(data, last, seq);
		@(negedge clk);
	endtask

	// Drops the input valid and waits until every predicted byte has come out,
	// then lets the block settle so it is truly idle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write transfer; the valid is lowered before returning so the
	// next write raises it in a later step.
	task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input cfg_t c);
		write_register(REG_FLAG,       c.flag_value);
		write_register(REG_ESCAPE,     c.escape_value);
		write_register(REG_FLAG_SUB,   c.flag_substitute);
		write_register(REG_ESCAPE_SUB, c.escape_substitute);
		write_register(REG_ADDRESS,    c.sender_address);
		write_register(REG_CTRL_SEQ0,  c.control_seq0);
		write_register(REG_CTRL_SEQ1,  c.control_seq1);
	endtask

	task automatic apply_random_settings(input bit flag_is_escape);
		cfg_t c;
		c.flag_value        = 8'($urandom_range(255));
		c.escape_value      = flag_is_escape ? c.flag_value : 8'($urandom_range(255));
		c.flag_substitute   = 8'($urandom_range(255));
		c.escape_substitute = 8'($urandom_range(255));
		c.sender_address    = 8'($urandom_range(255));
		c.control_seq0      = 8'($urandom_range(255));
		c.control_seq1      = 8'($urandom_range(255));
		apply_settings(c);
	endtask

	// Whole frames of random length, mostly short. Payload leans toward the
	// current flag and escape values so stuffing is hit often, and some frames
	// end with a byte chosen so that the data check itself needs stuffing.
	task automatic send_random_frames(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned roll;
		logic [7:0]  acc;
		logic [7:0]  b;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 16);
			acc = 8'h00;
			for (int unsigned i = 1; i <= len; i++) begin
				roll = $urandom_range(99);
				if (roll < 12)
					b = sb.regs.flag_value;
				else if (roll < 24)
					b = sb.regs.escape_value;
				else
					b = 8'($urandom_range(255));
				if (i == len && $urandom_range(99) < 20)
					b = acc ^ ($urandom_range(1) ? sb.regs.flag_value : sb.regs.escape_value);
				acc = acc ^ b;
				send_payload(b, i == len, 1'($urandom_range(1)));
			end
			sent += len;
		end
		wait_drained();
	endtask

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_FLAG;
		cfg_data     = 8'h00;
		send_gap_pct = 20;
		stall_pct    = 70;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-byte frames at both data extremes and both sequence bits.
		send_payload(8'h00, 1'b1, 1'b0);
		send_payload(8'hff, 1'b1, 1'b1);
		// Flag and escape in the payload; the sequence bit flips mid-frame and
		// must be ignored there.
		send_payload(8'h7e, 1'b0, 1'b1);
		send_payload(8'h7d, 1'b0, 1'b0);
		send_payload(8'h55, 1'b0, 1'b1);
		send_payload(8'haa, 1'b1, 1'b0);
		// Data check lands on the flag, then on the escape.
		send_payload(8'h12, 1'b0, 1'b0);
		send_payload(8'h6c, 1'b1, 1'b1);
		send_payload(8'h01, 1'b0, 1'b1);
		send_payload(8'h7c, 1'b1, 1'b0);
		// Register write in the middle of a frame, while the block is idle.
		send_payload(8'h11, 1'b0, 1'b0);
		wait_drained();
		write_register(REG_FLAG, 8'h11);
		send_payload(8'h11, 1'b1, 1'b1);
		wait_drained();
		// A write past the register map is dropped; 7e is plain data now.
		write_register(REG_UNMAPPED, 8'h7d);
		send_payload(8'h7e, 1'b1, 1'b0);
		wait_drained();
		// Flag and escape equal: the flag substitute is used.
		apply_settings('{8'h40, 8'h40, 8'h01, 8'h02, 8'h05, 8'h0a, 8'h0b});
		send_payload(8'h40, 1'b0, 1'b1);
		send_payload(8'h00, 1'b1, 1'b0);
		wait_drained();

		// Sender idles lightly, receiver stalls heavily.
		apply_settings(CFG_RESET);
		send_random_frames(60);
		apply_settings('{8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff});
		send_random_frames(60);

		// Sender idles heavily, receiver stalls lightly.
		send_gap_pct = 70;
		stall_pct    = 20;
		apply_random_settings(1'b0);
		send_random_frames(60);
		apply_settings('{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00});
		send_random_frames(60);

		// Full rate on both sides.
		send_gap_pct = 0;
		stall_pct    = 0;
		apply_random_settings(1'b1);
		send_random_frames(60);
		apply_random_settings(1'b0);
		send_random_frames(60);

		if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
			$display("info_frame_stuffing_encoder verification clean");
		else
			$display("info_frame_stuffing_encoder verification failed");
		$finish;
	end

endmodule
